>>> design/gkit_pkg.sv
// Shared types and constants for the group key index table.
package gkit_pkg;

   localparam int MaxKeys     = 256;
   localparam int MaxPostings = 1024;
   localparam int KeyIdxW     = $clog2(MaxKeys);
   localparam int KeyCntW     = $clog2(MaxKeys + 1);
   localparam int PostIdxW    = $clog2(MaxPostings);
   localparam int PostCntW    = $clog2(MaxPostings + 1);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_LOOKUP = 1'b1
   } mode_type;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] key_value;
      logic        [15:0] record_position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_position;
   } rsp_type;

endpackage

>>> design/gkit_req_if.sv
// Valid/ready channel interfaces for request and response words.
interface gkit_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic signed [31:0]   key_value;
   logic        [15:0]   record_position;
   modport source (output valid, mode, key_value, record_position, input ready);
   modport sink   (input valid, mode, key_value, record_position, output ready);
endinterface

interface gkit_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] found_position;
   modport source (output valid, status, found_position, input ready);
   modport sink   (input valid, status, found_position, output ready);
endinterface

>>> design/group_key_index_table.sv
// Lookup: binary search of the keys, then a read of the first posting of the key.
// Insert: key search, postings search, shifts of keys and postings, then offset bumps;
// the worst case is a new smallest key, which moves every key and posting.
// One item at a time in the engine; a two-word queue takes requests meanwhile.
// Synchronous active-high reset empties the table; memories are not cleared.
module group_key_index_table (
   input  logic       clock,
   input  logic       reset,
   gkit_req_if.sink   req,
   gkit_rsp_if.source rsp
);
   gkit_pkg::req_type q_data;
   gkit_pkg::rsp_type out_data;
   logic q_valid, q_pop, out_valid, busy;

   gkit_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
   );

   gkit_engine u_engine (
      .clock(clock), .reset(reset),
      .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
      .out_valid(out_valid), .out_data(out_data), .out_ready(rsp.ready),
      .busy(busy)
   );

   assign rsp.valid          = out_valid;
   assign rsp.status         = out_data.status;
   assign rsp.found_position = out_data.found_position;

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> busy) else $error("engine not busy after pop");
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == gkit_pkg::STATUS_OK ||
                     rsp.status == gkit_pkg::STATUS_NOT_FOUND ||
                     rsp.status == gkit_pkg::STATUS_FULL)) else $error("bad status");
endmodule

>>> design/gkit_front.sv
// Front end: takes request words and queues them for the engine.
module gkit_front (
   input  logic                clock,
   input  logic                reset,
   gkit_req_if.sink            req,
   output gkit_pkg::req_type   q_data,
   output logic                q_valid,
   input  logic                q_pop
);
   localparam int Depth = 2;

   gkit_pkg::req_type mem_ff [Depth];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req.ready = (cnt_ff != 2'(Depth));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push);
      rd_ptr_in = rd_ptr_ff + 1'(q_pop);
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{mode: req.mode, key_value: req.key_value,
                                record_position: req.record_position};
      end
   end
endmodule

>>> design/gkit_engine.sv
// Back end: key search, postings search and shift sequencer over three memories.
module gkit_engine (
   input  logic               clock,
   input  logic               reset,
   input  gkit_pkg::req_type  q_data,
   input  logic               q_valid,
   output logic               q_pop,
   output logic               out_valid,
   output gkit_pkg::rsp_type  out_data,
   input  logic               out_ready,
   output logic               busy
);
   localparam int KIW = gkit_pkg::KeyIdxW;
   localparam int KCW = gkit_pkg::KeyCntW;
   localparam int PIW = gkit_pkg::PostIdxW;
   localparam int PCW = gkit_pkg::PostCntW;

   typedef enum logic [11:0] {
      S_IDLE  = 12'h001,
      S_KRD   = 12'h002,
      S_KCMP  = 12'h004,
      S_DEC   = 12'h008,
      S_KSHR  = 12'h010,
      S_KSHW  = 12'h020,
      S_PRD   = 12'h040,
      S_PCMP  = 12'h080,
      S_PSHR  = 12'h100,
      S_PSHW  = 12'h200,
      S_BUMP  = 12'h400,
      S_OUT   = 12'h800
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] key_mem [gkit_pkg::MaxKeys];
   logic [PCW-1:0]     off_mem [gkit_pkg::MaxKeys];
   logic [15:0]        post_mem [gkit_pkg::MaxPostings];

   logic signed [31:0] krd_ff;
   logic [PCW-1:0]     ord_ff, ord2_ff;
   logic [15:0]        prd_ff;

   logic [KIW-1:0] kaddr, kaddr2, kwaddr;
   logic           kwe, owe;
   logic signed [31:0] kwdata;
   logic [PCW-1:0] owdata;
   logic [PIW-1:0] paddr, pwaddr;
   logic           pwe;
   logic [15:0]    pwdata;

   logic [KCW-1:0] key_count_ff, key_count_in;
   logic [PCW-1:0] post_count_ff, post_count_in;
   gkit_pkg::req_type cur_ff, cur_in;
   logic [KCW-1:0] lo_ff, lo_in, hi_ff, hi_in, kmid;
   logic [PCW-1:0] plo_ff, plo_in, phi_ff, phi_in, pmid;
   logic [KCW-1:0] i_ff, i_in;
   logic [PCW-1:0] j_ff, j_in;
   logic [PCW-1:0] off_ff, off_in;
   logic           key_hit;
   gkit_pkg::rsp_type rsp_ff, rsp_in;
   gkit_pkg::rsp_type out_ff, out_in;
   logic           rsp_valid_ff, rsp_valid_in;

   assign kmid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign pmid = plo_ff + ((phi_ff - plo_ff) >> 1);
   assign key_hit = (lo_ff < key_count_ff) && (krd_ff == cur_ff.key_value);

   always_comb begin
      state_in      = state_ff;
      key_count_in  = key_count_ff;
      post_count_in = post_count_ff;
      cur_in        = cur_ff;
      lo_in = lo_ff; hi_in = hi_ff; plo_in = plo_ff; phi_in = phi_ff;
      i_in = i_ff; j_in = j_ff; off_in = off_ff;
      rsp_in = rsp_ff; out_in = out_ff; rsp_valid_in = rsp_valid_ff;
      q_pop = 1'b0;
      kaddr = kmid[KIW-1:0]; kaddr2 = kmid[KIW-1:0];
      kwe = 1'b0; owe = 1'b0; kwaddr = i_ff[KIW-1:0];
      kwdata = krd_ff; owdata = ord_ff;
      paddr = pmid[PIW-1:0]; pwe = 1'b0; pwaddr = j_ff[PIW-1:0]; pwdata = prd_ff;
      if (rsp_valid_ff && out_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_data;
               lo_in  = '0;
               hi_in  = key_count_ff;
               state_in = S_KRD;
            end
         end
         S_KRD: begin
            // issue key read at midpoint, or at lo once the search ends
            if (lo_ff < hi_ff) state_in = S_KCMP;
            else begin
               kaddr  = lo_ff[KIW-1:0];
               kaddr2 = lo_ff[KIW-1:0];
               state_in = S_DEC;
            end
         end
         S_KCMP: begin
            if (krd_ff < cur_ff.key_value) lo_in = kmid + 1'b1;
            else hi_in = kmid;
            state_in = S_KRD;
         end
         S_DEC: begin
            // krd_ff/ord_ff hold entry at lo
            rsp_in    = '{status: gkit_pkg::STATUS_OK, found_position: '0};
            if (cur_ff.mode == gkit_pkg::MODE_LOOKUP) begin
               if (!key_hit) begin
                  rsp_in.status = gkit_pkg::STATUS_NOT_FOUND;
                  state_in = S_OUT;
               end else begin
                  plo_in = ord_ff; phi_in = ord_ff;
                  off_in = ord_ff;
                  paddr  = ord_ff[PIW-1:0];
                  state_in = S_PRD;
               end
            end else if ((!key_hit && key_count_ff == KCW'(gkit_pkg::MaxKeys)) ||
                         post_count_ff == PCW'(gkit_pkg::MaxPostings)) begin
               rsp_in.status = gkit_pkg::STATUS_FULL;
               state_in = S_OUT;
            end else if (!key_hit) begin
               off_in = (lo_ff < key_count_ff) ? ord_ff : post_count_ff;
               i_in   = key_count_ff;
               state_in = S_KSHR;
            end else begin
               off_in = ord_ff;
               i_in   = lo_ff;
               kaddr2 = KIW'(lo_ff + 1'b1);
               state_in = S_KSHW;
            end
         end
         S_KSHR: begin
            // open slot at lo: move entries down one at a time
            if (i_ff > lo_ff) begin
               kaddr = KIW'(i_ff - 1'b1); kaddr2 = KIW'(i_ff - 1'b1);
               state_in = S_KSHW;
            end else begin
               kwe = 1'b1; owe = 1'b1; kwaddr = lo_ff[KIW-1:0];
               kwdata = cur_ff.key_value; owdata = off_ff;
               key_count_in = key_count_ff + 1'b1;
               i_in = lo_ff;
               kaddr2 = KIW'(lo_ff + 1'b1);
               state_in = S_KSHW;
            end
         end
         S_KSHW: begin
            if (i_ff > lo_ff) begin
               kwe = 1'b1; owe = 1'b1;
               i_in = i_ff - 1'b1;
               state_in = S_KSHR;
            end else begin
               // ord2_ff holds offset of next key if any
               plo_in = off_ff;
               phi_in = (lo_ff + 1'b1 < key_count_ff) ? ord2_ff : post_count_ff;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            if (plo_ff < phi_ff) state_in = S_PCMP;
            else if (cur_ff.mode == gkit_pkg::MODE_LOOKUP) begin
               rsp_in.found_position = (off_ff < post_count_ff) ? prd_ff : 16'd0;
               state_in = S_OUT;
            end else begin
               j_in = post_count_ff;
               state_in = S_PSHR;
            end
         end
         S_PCMP: begin
            if (prd_ff < cur_ff.record_position) plo_in = pmid + 1'b1;
            else phi_in = pmid;
            state_in = S_PRD;
         end
         S_PSHR: begin
            if (j_ff > plo_ff) begin
               paddr = PIW'(j_ff - 1'b1);
               state_in = S_PSHW;
            end else begin
               pwe = 1'b1; pwaddr = plo_ff[PIW-1:0]; pwdata = cur_ff.record_position;
               post_count_in = post_count_ff + 1'b1;
               i_in = lo_ff + 1'b1;
               kaddr = KIW'(lo_ff + 1'b1); kaddr2 = KIW'(lo_ff + 1'b1);
               state_in = S_BUMP;
            end
         end
         S_PSHW: begin
            pwe = 1'b1;
            j_in = j_ff - 1'b1;
            state_in = S_PSHR;
         end
         S_BUMP: begin
            // one read leads each write: read i+1 while writing i
            if (i_ff < key_count_ff) begin
               owe = 1'b1; kwaddr = i_ff[KIW-1:0];
               owdata = ord_ff + 1'b1;
               kaddr = KIW'(i_ff + 1'b1); kaddr2 = KIW'(i_ff + 1'b1);
               i_in = i_ff + 1'b1;
            end else state_in = S_OUT;
         end
         S_OUT: begin
            // hand the word over only once the output register is free
            if (!rsp_valid_ff || out_ready) begin
               out_in = rsp_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Bump reads in the same cycle it writes, so it needs the old value at i registered
   // from the prior cycle; both ports read identical addresses there.
   always_ff @(posedge clock) begin
      krd_ff  <= key_mem[kaddr];
      ord_ff  <= off_mem[kaddr];
      ord2_ff <= off_mem[kaddr2];
      prd_ff  <= post_mem[paddr];
      if (kwe) key_mem[kwaddr] <= kwdata;
      if (owe) off_mem[kwaddr] <= owdata;
      if (pwe) post_mem[pwaddr] <= pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         key_count_ff  <= '0;
         post_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_count_ff  <= key_count_in;
         post_count_ff <= post_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff <= cur_in; lo_ff <= lo_in; hi_ff <= hi_in;
      plo_ff <= plo_in; phi_ff <= phi_in; i_ff <= i_in; j_ff <= j_in;
      off_ff <= off_in;
      rsp_ff <= rsp_in; out_ff <= out_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = out_ff;
   assign busy      = (state_ff != S_IDLE);
endmodule
